// ===== sv/pic_pkg.sv =====
// shared constants, types and request codes of the priority interrupt controller
package pic_pkg;

    // number of interrupt lines in use (1 to 64); storage is sized for 64
    localparam int NUM_LINES = 64;
    localparam int MAX_LINES = 64;
    localparam int LANES     = 4;
    localparam int MEM_ROWS  = MAX_LINES / LANES;
    localparam int NUM_ROWS  = (NUM_LINES + LANES - 1) / LANES;

    localparam logic [3:0]  LAST_ROW   = 4'(NUM_ROWS - 1);
    localparam logic [6:0]  LINE_LIMIT = 7'(NUM_LINES);
    localparam logic [63:0] LINE_MASK  =
        (NUM_LINES >= 64) ? {64{1'b1}} : ((64'd1 << NUM_LINES) - 64'd1);

    localparam logic [8:0] PRIO_NONE   = 9'd256;
    localparam logic [7:0] PRIO_LOWEST = 8'd255;

    typedef enum logic [3:0] {
        REQ_PULSE     = 4'd0,
        REQ_LINE_UP   = 4'd1,
        REQ_LINE_DOWN = 4'd2,
        REQ_ENABLE    = 4'd3,
        REQ_DISABLE   = 4'd4,
        REQ_CLEAR     = 4'd5,
        REQ_CLEAR_ALL = 4'd6,
        REQ_CLEAR_EN  = 4'd7,
        REQ_REEVAL    = 4'd8,
        REQ_SET_PRIO  = 4'd9,
        REQ_SET_RUN   = 4'd10,
        REQ_LOCK      = 4'd11,
        REQ_HARD      = 4'd12,
        REQ_READ      = 4'd13
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_HOLD
    } state_t;

endpackage

// ===== sv/priority_interrupt_controller.sv =====
// top level of the priority interrupt controller: line state, priority memory, winner scan
//
//  channel  dir  signals                          contents
//  s_*      in   s_tvalid s_tready s_tdata s_tuser  one event or register access
//  m_*      out  m_tvalid m_tready m_tdata          winner, wake and addressed-line fields
//
// after the accept edge the sequencer steps through the scan states, one per row, then the
// drain state, and loads the result in hold once the output slot is free; the next beat is
// taken in idle: the priority memory holds four lines per row, one row read and compared per cycle
// the line vectors, lock and running priority are updated on the accept edge
// a new beat is taken only in idle; a finished result waits in the output register
// so the next beat may enter while the previous result is still stalled
// reset clears every vector, sets the running priority to none and marks every
// priority entry unwritten, so it reads as the lowest priority
module priority_interrupt_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // irq_num[5:0], prio_value[14:6], lock_value[15]
    input  logic [3:0]  s_tuser,   // req_type[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // winner_valid[0], winner_irq[6:1], cpu_wake[7],
                                   // prev_lock[8], line_enabled[9], line_pending[10],
                                   // line_prio[18:11], running_prio_out[27:19], zero[31:28]
);

    // input beat fields
    pic_pkg::req_t in_req;
    logic [5:0]    in_irq;
    logic [8:0]    in_prio;
    logic          in_lock;
    logic          in_range;
    logic [63:0]   in_bit;
    logic          accept;

    assign in_req   = pic_pkg::req_t'(s_tuser);
    assign in_irq   = s_tdata[5:0];
    assign in_prio  = s_tdata[14:6];
    assign in_lock  = s_tdata[15];
    assign in_range = {1'b0, in_irq} < pic_pkg::LINE_LIMIT;
    assign in_bit   = in_range ? (64'd1 << in_irq) : 64'd0;
    assign accept   = s_tvalid && s_tready;

    // architectural state
    logic [63:0] level_reg,   level_next;
    logic [63:0] premask_reg, premask_next;
    logic [63:0] status_reg,  status_next;
    logic [63:0] enable_reg,  enable_next;
    logic [63:0] prio_vld_reg;
    logic [8:0]  running_reg, running_next;
    logic        lock_reg,    lock_next;

    // per-item registers
    logic [5:0]  irq_reg;
    logic        wake_reg,  wake_next;
    logic        prev_reg;

    // priority memory, four lines per row
    logic [pic_pkg::LANES-1:0][7:0] prio_mem [pic_pkg::MEM_ROWS];
    logic [pic_pkg::LANES-1:0][7:0] scan_data_reg;
    logic [pic_pkg::LANES-1:0][7:0] line_data_reg;
    logic        mem_we;

    // scan control
    pic_pkg::state_t state_reg, state_next;
    logic [3:0]  scan_row_reg, scan_row_next;
    logic [3:0]  cmp_row_reg,  cmp_row_next;
    logic        cmp_vld_reg,  cmp_vld_next;
    logic [8:0]  best_reg,     best_next;
    logic [5:0]  win_reg,      win_next;
    logic        found_reg,    found_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg;
    logic [31:0] out_data_next;
    logic        out_load;

    // event and access decoding, applied on the accept edge
    always_comb
    begin
        level_next   = level_reg;
        premask_next = premask_reg;
        status_next  = status_reg;
        enable_next  = enable_reg;
        running_next = running_reg;
        lock_next    = lock_reg;
        wake_next    = 1'b0;
        mem_we       = 1'b0;
        unique case (in_req)
            pic_pkg::REQ_PULSE:
            begin
                if (in_range)
                begin
                    premask_next = premask_reg | in_bit;
                    status_next  = status_reg | (in_bit & enable_reg);
                    wake_next    = !lock_reg;
                end
            end
            pic_pkg::REQ_LINE_UP:
            begin
                // only a rising level pends the line
                if (in_range && ((level_reg & in_bit) == 64'd0))
                begin
                    level_next   = level_reg | in_bit;
                    premask_next = premask_reg | in_bit;
                    status_next  = status_reg | (in_bit & enable_reg);
                    wake_next    = !lock_reg;
                end
            end
            pic_pkg::REQ_LINE_DOWN:
            begin
                level_next = level_reg & ~in_bit;
            end
            pic_pkg::REQ_ENABLE:
            begin
                if (in_range)
                begin
                    enable_next = enable_reg | in_bit;
                    if ((premask_reg & in_bit) != 64'd0)
                    begin
                        status_next = status_reg | in_bit;
                        wake_next   = !lock_reg;
                    end
                end
            end
            pic_pkg::REQ_DISABLE:
            begin
                enable_next = enable_reg & ~in_bit;
            end
            pic_pkg::REQ_CLEAR:
            begin
                status_next  = status_reg & ~in_bit;
                premask_next = premask_reg & ~in_bit;
            end
            pic_pkg::REQ_CLEAR_ALL:
            begin
                status_next  = 64'd0;
                premask_next = 64'd0;
            end
            pic_pkg::REQ_CLEAR_EN:
            begin
                status_next  = 64'd0;
                premask_next = premask_reg & ~enable_reg;
            end
            pic_pkg::REQ_REEVAL:
            begin
                // re-pend a line still held high, no wake
                if ((level_reg & in_bit) != 64'd0)
                begin
                    premask_next = premask_reg | in_bit;
                    status_next  = status_reg | (in_bit & enable_reg);
                end
            end
            pic_pkg::REQ_SET_PRIO:
            begin
                mem_we = in_range;
            end
            pic_pkg::REQ_SET_RUN:
            begin
                running_next = in_prio;
            end
            pic_pkg::REQ_LOCK:
            begin
                lock_next = in_lock;
                wake_next = lock_reg && !in_lock && (status_reg != 64'd0);
            end
            pic_pkg::REQ_HARD:
            begin
                // wakes even while locked; the override is spent in this step
                wake_next = 1'b1;
            end
            default:
            begin
                wake_next = 1'b0;
            end
        endcase
        status_next  = status_next & pic_pkg::LINE_MASK;
        premask_next = premask_next & pic_pkg::LINE_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= 64'd0;
            premask_reg  <= 64'd0;
            status_reg   <= 64'd0;
            enable_reg   <= 64'd0;
            prio_vld_reg <= 64'd0;
            running_reg  <= pic_pkg::PRIO_NONE;
            lock_reg     <= 1'b0;
        end
        else if (accept)
        begin
            level_reg   <= level_next;
            premask_reg <= premask_next;
            status_reg  <= status_next;
            enable_reg  <= enable_next;
            running_reg <= running_next;
            lock_reg    <= lock_next;
            if (mem_we)
            begin
                prio_vld_reg[in_irq] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            irq_reg  <= in_irq;
            wake_reg <= wake_next;
            prev_reg <= lock_reg;
        end
    end

    // priority memory: one write port, a scan read port and an addressed-line read port
    always_ff @(posedge clk)
    begin
        if (accept && mem_we)
        begin
            prio_mem[in_irq[5:2]][in_irq[1:0]] <= in_prio[7:0];
        end
        scan_data_reg <= prio_mem[scan_row_reg];
        line_data_reg <= prio_mem[irq_reg[5:2]];
    end

    // compare one row of four lines, lowest line first so ties keep the lower index
    always_comb
    begin
        logic [5:0] line;
        logic [7:0] p;
        line       = 6'd0;
        p          = 8'd0;
        best_next  = best_reg;
        win_next   = win_reg;
        found_next = found_reg;
        if (cmp_vld_reg)
        begin
            for (int k = 0; k < pic_pkg::LANES; k++)
            begin
                line = {cmp_row_reg, 2'(k)};
                p    = prio_vld_reg[line] ? scan_data_reg[k] : pic_pkg::PRIO_LOWEST;
                if (status_reg[line] && ({1'b0, p} < best_next) && ({1'b0, p} < running_reg))
                begin
                    best_next  = {1'b0, p};
                    win_next   = line;
                    found_next = 1'b1;
                end
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        scan_row_next  = scan_row_reg;
        cmp_row_next   = cmp_row_reg;
        cmp_vld_next   = 1'b0;
        out_load       = 1'b0;
        s_tready       = 1'b0;
        unique case (state_reg)
            pic_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    scan_row_next = 4'd0;
                    state_next    = pic_pkg::ST_SCAN;
                end
            end
            pic_pkg::ST_SCAN:
            begin
                cmp_vld_next = 1'b1;
                cmp_row_next = scan_row_reg;
                if (scan_row_reg == pic_pkg::LAST_ROW)
                begin
                    state_next = pic_pkg::ST_DRAIN;
                end
                else
                begin
                    scan_row_next = scan_row_reg + 4'd1;
                end
            end
            pic_pkg::ST_DRAIN:
            begin
                state_next = pic_pkg::ST_HOLD;
            end
            pic_pkg::ST_HOLD:
            begin
                // wait for the output slot to free up
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = pic_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pic_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pic_pkg::ST_IDLE;
            scan_row_reg <= 4'd0;
            cmp_row_reg  <= 4'd0;
            cmp_vld_reg  <= 1'b0;
            best_reg     <= pic_pkg::PRIO_NONE;
            win_reg      <= 6'd0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_row_reg <= scan_row_next;
            cmp_row_reg  <= cmp_row_next;
            cmp_vld_reg  <= cmp_vld_next;
            if (accept)
            begin
                best_reg  <= pic_pkg::PRIO_NONE;
                win_reg   <= 6'd0;
                found_reg <= 1'b0;
            end
            else
            begin
                best_reg  <= best_next;
                win_reg   <= win_next;
                found_reg <= found_next;
            end
        end
    end

    // result assembly from the post-step state
    always_comb
    begin
        logic       hit;
        logic       rng;
        logic [7:0] lprio;
        hit   = found_reg && !lock_reg;
        rng   = {1'b0, irq_reg} < pic_pkg::LINE_LIMIT;
        lprio = !rng ? 8'd0 :
                (prio_vld_reg[irq_reg] ? line_data_reg[irq_reg[1:0]] : pic_pkg::PRIO_LOWEST);
        out_data_next = {4'd0,
                         running_reg,
                         lprio,
                         rng && premask_reg[irq_reg],
                         rng && enable_reg[irq_reg],
                         prev_reg,
                         wake_reg,
                         hit ? win_reg : 6'd0,
                         hit};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
